FILE: src/stm_pkg.sv
// Shared types, codes and defaults for the soft timer multiplexer.
package stm_pkg;

    localparam int NUM_TIMERS_DEFAULT = 8;
    localparam int TIME_W = 16;
    localparam int MASK_W = 32;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_ONCE   = 2'd1,
        MODE_REPEAT = 2'd2
    } timer_mode_t;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_SET  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_DONE
    } stm_state_t;

    typedef struct packed {
        logic        func;
        logic [2:0]  timer_index;
        logic [15:0] tick_period;
        logic [1:0]  timer_mode;
        logic [31:0] event_mask;
    } stm_in_t;

    typedef struct packed {
        logic [31:0] fired_flags;
        logic [15:0] next_expire;
        logic        compare_enabled;
        logic [15:0] counter_value;
    } stm_out_t;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic              apply;
        logic              fire_en;
        logic [TIME_W-1:0] compare_value;
        logic [TIME_W-1:0] counter_value;
    } cell_ctrl_t;

    // Running result handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] expiry;
        logic [MASK_W-1:0] flags;
    } scan_t;

endpackage

FILE: src/stm_if.sv
// Valid/ready channels carrying input items and result items.
interface stm_in_if import stm_pkg::*;;
    logic    valid;
    logic    ready;
    stm_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stm_out_if import stm_pkg::*;;
    logic     valid;
    logic     ready;
    stm_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: src/stm_cell.sv
// One timer slot: holds its mode, period, expiry and mask, and folds itself into the scan.
module stm_cell import stm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       wr_en,
    input  stm_in_t    wr_item,
    input  scan_t      scan_in,
    output scan_t      scan_out
);

    timer_mode_t       mode_reg, mode_next;
    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] expiry_reg, expiry_next;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] fired_reg, fired_next;
    scan_t             scan_reg, scan_next;

    logic              live;
    logic              hit;
    logic [TIME_W-1:0] gap;
    logic              take;

    assign live = (mode_reg == MODE_ONCE) || (mode_reg == MODE_REPEAT);
    assign hit  = ctrl.fire_en && live && (expiry_reg == ctrl.compare_value);
    assign gap  = ctrl.counter_value - expiry_reg;
    assign take = live && (!scan_in.found || (gap < scan_in.gap));

    always_comb
    begin
        mode_next   = mode_reg;
        expiry_next = expiry_reg;
        fired_next  = fired_reg;
        if (ctrl.apply)
        begin
            fired_next = hit ? mask_reg : '0;
            if (wr_en)
            begin
                case (wr_item.timer_mode)
                    MODE_ONCE:   mode_next = MODE_ONCE;
                    MODE_REPEAT: mode_next = MODE_REPEAT;
                    default:     mode_next = MODE_OFF;
                endcase
                expiry_next = ctrl.counter_value - wr_item.tick_period;
            end
            else if (hit)
            begin
                // once timers drop out, repeat timers reload from the compare point
                if (mode_reg == MODE_ONCE)
                    mode_next = MODE_OFF;
                else
                    expiry_next = ctrl.compare_value - period_reg;
            end
        end
    end

    always_comb
    begin
        scan_next.found  = scan_in.found || take;
        scan_next.gap    = take ? gap : scan_in.gap;
        scan_next.expiry = take ? expiry_reg : scan_in.expiry;
        scan_next.flags  = scan_in.flags | fired_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_OFF;
        else
            mode_reg <= mode_next;
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        fired_reg  <= fired_next;
        scan_reg   <= scan_next;
        if (ctrl.apply && wr_en)
        begin
            period_reg <= wr_item.tick_period;
            mask_reg   <= wr_item.event_mask;
        end
    end

    assign scan_out = scan_reg;

endmodule

FILE: src/soft_timer_multiplexer.sv
// Top level: counter, compare register, sequencer and the chain of timer cells.
// Soft timer multiplexer. NUM_TIMERS soft timers share one 16-bit down-counter
// and one compare register; each item is either a tick or a set of one timer.
// Items are taken one at a time: the block takes an item, updates the counter
// and the timer cells, passes the running minimum and fired flags down the
// chain of cells, and loads the result register; only then is the next item
// taken. The result register holds a finished result while the next item is
// taken. There is no clearing pass after reset.
module soft_timer_multiplexer import stm_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
)
(
    input logic          clk,
    input logic          rst_n,
    stm_in_if.sink       cmd,
    stm_out_if.source    result
);

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    stm_state_t        state_reg, state_next;
    stm_in_t           item_reg;
    logic [TIME_W-1:0] counter_reg, counter_next;
    logic [TIME_W-1:0] compare_reg, compare_next;
    logic              armed_reg, armed_next;
    logic              rechoose_reg, rechoose_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              out_valid_reg, out_valid_next;
    stm_out_t          out_data_reg, out_data_next;

    cell_ctrl_t        ctrl;
    logic [NUM_TIMERS-1:0] wr_en;
    scan_t             chain [NUM_TIMERS+1];
    logic              is_set;
    logic              match;

    assign is_set   = (item_reg.func == FUNC_SET);
    assign match    = armed_reg && ((counter_reg - 16'd1) == compare_reg);
    assign chain[0] = '0;

    assign ctrl.apply         = (state_reg == ST_APPLY);
    assign ctrl.fire_en       = !is_set && match;
    assign ctrl.compare_value = compare_reg;
    assign ctrl.counter_value = counter_reg;

    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        assign wr_en[i] = is_set && (32'(item_reg.timer_index) == 32'(i));

        stm_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .wr_en    (wr_en[i]),
            .wr_item  (item_reg),
            .scan_in  (chain[i]),
            .scan_out (chain[i+1])
        );
    end

    assign cmd.ready    = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        counter_next   = counter_reg;
        compare_next   = compare_reg;
        armed_next     = armed_reg;
        rechoose_next  = rechoose_reg;
        scan_cnt_next  = scan_cnt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (result.valid && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                    state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (is_set)
                begin
                    rechoose_next = 1'b1;
                end
                else
                begin
                    counter_next  = counter_reg - 16'd1;
                    rechoose_next = match;
                end
                scan_cnt_next = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == CNT_W'(NUM_TIMERS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the result register is free
                if (!out_valid_reg || result.ready)
                begin
                    if (rechoose_reg)
                    begin
                        armed_next = chain[NUM_TIMERS].found;
                        if (chain[NUM_TIMERS].found)
                            compare_next = chain[NUM_TIMERS].expiry;
                    end
                    out_valid_next                = 1'b1;
                    out_data_next.fired_flags     = chain[NUM_TIMERS].flags;
                    out_data_next.next_expire     = armed_next ? compare_next : '0;
                    out_data_next.compare_enabled = armed_next;
                    out_data_next.counter_value   = counter_reg;
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            counter_reg   <= '0;
            compare_reg   <= '0;
            armed_reg     <= 1'b0;
            rechoose_reg  <= 1'b0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            compare_reg   <= compare_next;
            armed_reg     <= armed_next;
            rechoose_reg  <= rechoose_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (cmd.valid && cmd.ready)
            item_reg <= cmd.data;
    end

endmodule
